@@ hdl/psr_pkg.sv @@
// Shared types and constants of the polyphase sinc resampler.
package psr_pkg;

    // Fixed field widths of the item payloads.
    localparam int SAMPLE_W = 16;
    localparam int COEF_IN_W = 16;
    localparam int TAP_IDX_W = 11;
    localparam int RATIO_W = 20;
    localparam int PHASE_W = 20;
    localparam int FRAC_W = 11;

    // Blended coefficient and product widths inside the MAC unit.
    localparam int COEF_W = 30;
    localparam int PROD_W = SAMPLE_W + COEF_W;

    // Phase constants in unsigned Q16.
    localparam logic [PHASE_W-1:0] ONE_Q16 = 20'h10000;
    localparam logic [PHASE_W-1:0] PHASE_MAX = 20'hFFFFF;
    localparam logic [RATIO_W-1:0] RATIO_RESET = 20'h10000;

    // Rounding shift: products are in Q26, so one half is 1 << (ROUND_SHIFT - 1).
    localparam int ROUND_SHIFT = 26;

    // Saturation limits as magnitudes.
    localparam logic [SAMPLE_W:0] SAT_POS = 17'd32767;
    localparam logic [SAMPLE_W:0] SAT_NEG = 17'd32768;

    // Run index of the last output that one input sample may cause.
    localparam logic [2:0] LAST_RUN_IDX = 3'd7;

    // Operation codes carried in the input tuser.
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_KWRITE = 1'b1;

    // Register word select (paddr bit 2).
    localparam logic REG_RATIO = 1'b0;

    // Sequencer states.
    typedef enum logic [2:0] {
        S_IDLE,
        S_SETUP,
        S_BASE,
        S_MAC,
        S_DRAIN,
        S_RND1,
        S_RND2
    } t_state;

    // Control of the shared MAC unit.
    typedef struct packed {
        logic vld;    // kernel pair and sample valid this cycle
        logic first;  // first tap of a dot product: restart the accumulator
        logic rnd;    // take the magnitude of the finished accumulator
    } t_mac_ctl;

endpackage

@@ hdl/polyphase_sinc_resampler.sv @@
// Top level of the polyphase windowed-sinc sample rate converter.
//
//  Channel   Direction  Contents
//  s_axis    in         tdata: sample_in, tap_index, tap_value; tuser: operation;
//                       tlast: block_last
//  m_axis    out        tdata: sample_out; tuser: block_end; tlast: run_last
//  APB       in/out     ratio_q16 at byte address 0
//
// A kernel write, and a sample push with the phase at or above one, leave the
// sequencer in S_IDLE; otherwise each output is computed by the one MAC unit
// that walks the taps one per cycle, and a push may cause up to eight.
// Reset is synchronous, clears history, phase and control state and sets the ratio
// to one in Q16; the kernel table is not cleared. A result waits in the output register; when it
// is not taken the sequencer holds before loading the next one.
module polyphase_sinc_resampler
    import psr_pkg::*;
#(
    parameter int TAPS = 32,
    parameter int PHASES = 32
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,   // sample_in[15:0], tap_index[26:16], tap_value[42:27]
    input  logic        s_axis_tuser,   // operation
    input  logic        s_axis_tlast,
    // Result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [15:0] m_axis_tdata,   // sample_out[15:0]
    output logic        m_axis_tuser,   // block_end
    output logic        m_axis_tlast,
    // Configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int KSIZE = (PHASES + 1) * TAPS;
    localparam int KAW = $clog2(KSIZE);
    localparam int TCW = $clog2(TAPS);
    localparam int RW = $clog2(PHASES);
    localparam int XW = 16 + $clog2(PHASES + 1);
    localparam logic [TCW-1:0] TAP_LAST = TCW'(TAPS - 1);
    localparam logic [TCW-1:0] DRAIN_LAST = TCW'(2);

    t_state r_state, n_state;

    logic signed [SAMPLE_W-1:0]  r_hist [TAPS];
    logic signed [COEF_IN_W-1:0] r_kmem [KSIZE];
    logic signed [COEF_IN_W-1:0] r_k1;
    logic signed [COEF_IN_W-1:0] r_k2;
    logic signed [SAMPLE_W-1:0]  r_h_d1;
    logic                        r_iss_d1;
    logic                        r_first_d1;

    logic [PHASE_W-1:0] r_phase;
    logic [RATIO_W-1:0] r_ratio;
    logic [PHASE_W-1:0] r_psum;
    logic               r_more;
    logic [2:0]         r_n;
    logic               r_blast;
    logic [RW-1:0]      r_row;
    logic [FRAC_W-1:0]  r_w;
    logic [TCW-1:0]     r_cnt;
    logic [KAW-1:0]     r_addr1;
    logic [KAW-1:0]     r_addr2;

    logic               r_out_vld;
    logic [15:0]        r_out_data;
    logic               r_out_last;
    logic               r_out_end;

    logic               s_push;
    logic               s_kwrite;
    logic               s_issue;
    logic               s_rnd;
    logic               s_load;
    logic               phase_lt_one;
    logic [31:0]        widx;
    logic [XW-1:0]      x;
    logic [XW-17:0]     row_raw;
    logic [PHASE_W:0]   psum_raw;
    logic [PHASE_W-1:0] psum_sat;
    logic [KAW-1:0]     base;
    logic               cfg_wr;
    t_mac_ctl           mac_ctl;
    logic signed [SAMPLE_W-1:0] mac_sample;

    assign phase_lt_one = (r_phase[PHASE_W-1:16] == '0);
    assign widx = 32'(s_axis_tdata[26:16]);

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE:  if (s_push && phase_lt_one) n_state = S_SETUP;
            S_SETUP: n_state = S_BASE;
            S_BASE:  n_state = S_MAC;
            S_MAC:   if (r_cnt == TAP_LAST) n_state = S_DRAIN;
            S_DRAIN: if (r_cnt == DRAIN_LAST) n_state = S_RND1;
            S_RND1:  n_state = S_RND2;
            S_RND2: begin
                if (s_load) begin
                    n_state = r_more ? S_SETUP : S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // Sequencer strobes. The input is held off while reset is applied.
    always_comb begin
        s_axis_tready = 1'b0;
        s_issue = 1'b0;
        s_rnd = 1'b0;
        s_load = 1'b0;
        unique case (r_state)
            S_IDLE:  s_axis_tready = i_rst_n;
            S_MAC:   s_issue = 1'b1;
            S_RND1:  s_rnd = 1'b1;
            S_RND2:  s_load = !r_out_vld || m_axis_tready;
            default: ;
        endcase
        s_push = s_axis_tready && s_axis_tvalid && (s_axis_tuser == OP_PUSH);
        s_kwrite = s_axis_tready && s_axis_tvalid && (s_axis_tuser == OP_KWRITE);
    end

    // Kernel row and blend weight from the phase fraction, and the saturated next phase.
    always_comb begin
        x = XW'(r_phase[15:0]) * XW'(PHASES);
        row_raw = x[XW-1:16];
        base = KAW'(r_row) * KAW'(TAPS);
        psum_raw = {1'b0, r_phase} + {1'b0, r_ratio};
        psum_sat = psum_raw[PHASE_W] ? PHASE_MAX : psum_raw[PHASE_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sample history: a push shifts in the new sample; each tap issue rotates the line
    // by one, so after a full walk of the taps the oldest sample is back at the head.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int j = 0; j < TAPS; j++) begin
                r_hist[j] <= '0;
            end
        end else if (s_push || s_issue) begin
            for (int j = 0; j < TAPS - 1; j++) begin
                r_hist[j] <= r_hist[j+1];
            end
            r_hist[TAPS-1] <= s_push ? $signed(s_axis_tdata[15:0]) : r_hist[0];
        end
    end

    // Kernel table: one write port, two registered read ports.
    always_ff @(posedge i_clk) begin
        if (s_kwrite && (widx < 32'(KSIZE))) begin
            r_kmem[widx[KAW-1:0]] <= $signed(s_axis_tdata[42:27]);
        end
        r_k1 <= r_kmem[r_addr1];
        r_k2 <= r_kmem[r_addr2];
        r_h_d1 <= r_hist[0];
    end

    // Phase, run count and tap walk.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= '0;
            r_n <= '0;
            r_cnt <= '0;
            r_more <= 1'b0;
            r_iss_d1 <= 1'b0;
            r_first_d1 <= 1'b0;
        end else begin
            r_iss_d1 <= s_issue;
            r_first_d1 <= s_issue && (r_cnt == '0);
            if (s_push) begin
                r_n <= '0;
                if (!phase_lt_one) begin
                    r_phase <= r_phase - ONE_Q16;
                end
            end
            if (r_state == S_BASE) begin
                r_cnt <= '0;
            end else if (r_state == S_MAC) begin
                r_cnt <= (r_cnt == TAP_LAST) ? '0 : r_cnt + 1'b1;
            end else if (r_state == S_DRAIN) begin
                r_cnt <= r_cnt + 1'b1;
            end
            if (s_rnd) begin
                r_more <= (psum_sat[PHASE_W-1:16] == '0) && (r_n != LAST_RUN_IDX);
            end
            if (s_load) begin
                if (r_more) begin
                    r_phase <= r_psum;
                    r_n <= r_n + 1'b1;
                end else begin
                    r_phase <= (r_psum[PHASE_W-1:16] != '0) ? r_psum - ONE_Q16 : '0;
                end
            end
        end
    end

    // Per-output setup registers.
    always_ff @(posedge i_clk) begin
        if (s_push) begin
            r_blast <= s_axis_tlast;
        end
        if (r_state == S_SETUP) begin
            r_row <= (row_raw > (XW-16)'(PHASES - 1)) ? RW'(PHASES - 1) : RW'(row_raw);
            r_w <= x[15:5];
        end
        if (r_state == S_BASE) begin
            r_addr1 <= base;
            r_addr2 <= base + KAW'(TAPS);
        end else if (s_issue) begin
            r_addr1 <= r_addr1 + 1'b1;
            r_addr2 <= r_addr2 + 1'b1;
        end
        if (s_rnd) begin
            r_psum <= psum_sat;
        end
    end

    assign mac_ctl = '{vld: r_iss_d1, first: r_first_d1, rnd: s_rnd};

    psr_mac #(
        .TAPS(TAPS)
    ) u_mac (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (mac_ctl),
        .i_k1    (r_k1),
        .i_k2    (r_k2),
        .i_h     (r_h_d1),
        .i_w     (r_w),
        .o_sample(mac_sample)
    );

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld <= 1'b0;
        end else if (s_load) begin
            r_out_vld <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_load) begin
            r_out_data <= mac_sample;
            r_out_last <= !r_more;
            r_out_end <= !r_more && r_blast;
        end
    end

    assign m_axis_tvalid = r_out_vld;
    assign m_axis_tdata = r_out_data;
    assign m_axis_tlast = r_out_last;
    assign m_axis_tuser = r_out_end;

    // Configuration register.
    assign cfg_wr = psel && penable && pwrite && pready;
    assign pready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ratio <= RATIO_RESET;
        end else if (cfg_wr && (paddr[2] == REG_RATIO)) begin
            r_ratio <= pwdata[RATIO_W-1:0];
        end
    end

    assign prdata = (paddr[2] == REG_RATIO) ? 32'(r_ratio) : '0;

endmodule

@@ hdl/psr_mac.sv @@
// Shared multiply-accumulate unit: coefficient blend, product, accumulator and rounding.
module psr_mac
    import psr_pkg::*;
#(
    parameter int TAPS = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  t_mac_ctl                    i_ctl,
    input  logic signed [COEF_IN_W-1:0] i_k1,
    input  logic signed [COEF_IN_W-1:0] i_k2,
    input  logic signed [SAMPLE_W-1:0]  i_h,
    input  logic        [FRAC_W-1:0]    i_w,
    output logic signed [SAMPLE_W-1:0]  o_sample
);

    localparam int ACC_W = PROD_W + $clog2(TAPS);
    localparam int RND_W = ACC_W - ROUND_SHIFT + 1;

    logic signed [COEF_W-1:0]   r_c;
    logic signed [SAMPLE_W-1:0] r_h;
    logic                       r_vb;
    logic                       r_fb;
    logic signed [PROD_W-1:0]   r_p;
    logic                       r_vc;
    logic                       r_fc;
    logic signed [ACC_W-1:0]    r_acc;
    logic        [ACC_W-1:0]    r_mag;
    logic                       r_neg;

    logic signed [COEF_IN_W:0]  diff;
    logic signed [COEF_W-1:0]   coef;
    logic        [RND_W-1:0]    rounded;
    logic        [SAMPLE_W:0]   limit;
    logic        [SAMPLE_W:0]   clipped;

    // Blend the two adjacent kernel rows into one coefficient:
    // k1*2048 + (k2-k1)*w equals k1*(2048-w) + k2*w.
    always_comb begin
        diff = (COEF_IN_W+1)'(i_k2) - (COEF_IN_W+1)'(i_k1);
        coef = (COEF_W'(i_k1) <<< FRAC_W)
             + COEF_W'(diff) * COEF_W'($signed({1'b0, i_w}));
    end

    // Pipeline control of the stages.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vb <= 1'b0;
            r_fb <= 1'b0;
            r_vc <= 1'b0;
            r_fc <= 1'b0;
        end else begin
            r_vb <= i_ctl.vld;
            r_fb <= i_ctl.first;
            r_vc <= r_vb;
            r_fc <= r_fb;
        end
    end

    // Blend, multiply and accumulate stages, and the magnitude capture for rounding.
    always_ff @(posedge i_clk) begin
        r_c <= coef;
        r_h <= i_h;
        r_p <= PROD_W'(r_h) * PROD_W'(r_c);
        if (r_vc) begin
            if (r_fc) begin
                r_acc <= ACC_W'(r_p);
            end else begin
                r_acc <= r_acc + ACC_W'(r_p);
            end
        end
        if (i_ctl.rnd) begin
            r_neg <= r_acc[ACC_W-1];
            r_mag <= r_acc[ACC_W-1] ? ACC_W'(-r_acc) : ACC_W'(r_acc);
        end
    end

    // Round half away from zero, then saturate to the sample range.
    always_comb begin
        rounded = RND_W'(({1'b0, r_mag} + (ACC_W+1)'(1 << (ROUND_SHIFT - 1))) >> ROUND_SHIFT);
        limit = r_neg ? SAT_NEG : SAT_POS;
        clipped = (rounded > RND_W'(limit)) ? limit : (SAMPLE_W+1)'(rounded);
        o_sample = r_neg ? SAMPLE_W'(-clipped) : SAMPLE_W'(clipped);
    end

endmodule
